// ----- rtl/core/lspd_pkg.sv -----
// Package for the long/short press detector.
// Holds the operation, event and sequencer codes and the per-channel entry layout.
// No dependencies.
package lspd_pkg;

  localparam int unsigned DelayWidth = 16;
  localparam int unsigned ChanWidth  = 3;
  localparam logic [DelayWidth-1:0] DelayReset = 16'd500;

  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_TICK   = 2'd1,
    OP_FLUSH  = 2'd2,
    OP_QUERY  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_SHORT = 2'd1,
    EV_LONG  = 2'd2
  } event_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_e;

  typedef enum logic {
    REG_PRESS_DELAY = 1'b0
  } reg_e;

  typedef struct packed {
    logic                  held;
    logic [1:0]            ev_now;
    logic [1:0]            ev_flush;
    logic                  armed;
    logic [DelayWidth-1:0] ticks;
  } entry_t;

  localparam int unsigned EntryWidth = $bits(entry_t);

endpackage

// ----- rtl/core/lspd_intf.sv -----
// Valid/ready channel interfaces for the press detector items and results.
// Depends on lspd_pkg for field widths.
interface lspd_in_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     op;
  logic [lspd_pkg::ChanWidth-1:0] channel;
  logic                           level;

  modport source (output valid, output op, output channel, output level, input ready);
  modport sink   (input valid, input op, input channel, input level, output ready);
endinterface

interface lspd_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] event_value;
  logic       event_edge;

  modport source (output valid, output event_value, output event_edge, input ready);
  modport sink   (input valid, input event_value, input event_edge, output ready);
endinterface

// ----- rtl/core/lspd_ram.sv -----
// Generic single-write, single-read synchronous RAM with a registered read.
// No dependencies.
module lspd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ----- rtl/core/lspd_cfg.sv -----
// APB-style configuration register file holding the shared press delay.
// Depends on lspd_pkg.
module lspd_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [2:0]                       paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  output logic [lspd_pkg::DelayWidth-1:0]  delay_o
);

  logic [lspd_pkg::DelayWidth-1:0] delay_q, delay_d;
  logic                            hit;

  assign hit    = (paddr[2] == lspd_pkg::REG_PRESS_DELAY);
  assign pready = 1'b1;

  always_comb begin
    delay_d = delay_q;
    if (psel && penable && pwrite && hit) begin
      delay_d = pwdata[lspd_pkg::DelayWidth-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q <= lspd_pkg::DelayReset;
    end else begin
      delay_q <= delay_d;
    end
  end

  assign prdata  = hit ? {{(32 - lspd_pkg::DelayWidth){1'b0}}, delay_q} : 32'd0;
  assign delay_o = delay_q;

endmodule

// ----- rtl/core/lspd_ctrl.sv -----
// Sequencer that reads, updates and writes back channel entries in the state RAM.
// Depends on lspd_pkg, lspd_intf and lspd_ram.
module lspd_ctrl #(
  parameter int unsigned CHANNELS = 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [lspd_pkg::DelayWidth-1:0] delay_i,
  lspd_in_if.sink                         in_i,
  lspd_out_if.source                      out_o
);

  localparam int unsigned IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [IW-1:0] LastIdx = IW'(CHANNELS - 1);

  lspd_pkg::state_e state_q, state_d;
  lspd_pkg::op_e    op_q, op_d;
  logic [IW-1:0]    ch_idx_q, ch_idx_d;
  logic             ch_ok_q, ch_ok_d;
  logic             lvl_q, lvl_d;
  logic             sweep_q, sweep_d;
  logic             rd_busy_q, rd_busy_d;
  logic [IW-1:0]    rd_idx_q, rd_idx_d;
  logic             pend_q, pend_d;
  logic [IW-1:0]    wr_idx_q, wr_idx_d;
  logic [1:0]       res_val_q, res_val_d;
  logic             res_edge_q, res_edge_d;
  logic             out_valid_q, out_valid_d;
  logic [1:0]       out_val_q, out_val_d;
  logic             out_edge_q, out_edge_d;
  logic [CHANNELS-1:0] vld_q, vld_d;

  logic [lspd_pkg::EntryWidth-1:0] rdata;
  lspd_pkg::entry_t cur, upd;
  logic             we;
  logic             in_ok, in_sweep, in_valid_ch;

  lspd_ram #(
    .WIDTH (lspd_pkg::EntryWidth),
    .DEPTH (CHANNELS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (wr_idx_q),
    .wdata_i (upd),
    .re_i    (rd_busy_q && (state_q == lspd_pkg::ST_RUN)),
    .raddr_i (rd_idx_q),
    .rdata_o (rdata)
  );

  assign in_ok       = in_i.valid && in_i.ready;
  assign in_valid_ch = (32'(in_i.channel) < CHANNELS);
  assign in_sweep    = (lspd_pkg::op_e'(in_i.op) == lspd_pkg::OP_TICK) ||
                       (lspd_pkg::op_e'(in_i.op) == lspd_pkg::OP_FLUSH);
  assign in_i.ready  = (state_q == lspd_pkg::ST_IDLE);

  always_comb begin
    cur = vld_q[wr_idx_q] ? lspd_pkg::entry_t'(rdata) : '0;
    upd = cur;
    case (op_q)
      lspd_pkg::OP_SAMPLE: begin
        if (lvl_q != cur.held) begin
          if (lvl_q) begin
            upd.armed = 1'b1;
            upd.ticks = delay_i;
          end else if (cur.ev_now == lspd_pkg::EV_LONG) begin
            upd.ev_now = lspd_pkg::EV_NONE;
          end else begin
            upd.armed  = 1'b0;
            upd.ticks  = '0;
            upd.ev_now = lspd_pkg::EV_SHORT;
          end
          upd.held = lvl_q;
        end
      end
      lspd_pkg::OP_TICK: begin
        if (cur.armed) begin
          if (cur.ticks <= lspd_pkg::DelayWidth'(1)) begin
            upd.ev_now = lspd_pkg::EV_LONG;
            upd.armed  = 1'b0;
            upd.ticks  = '0;
          end else begin
            upd.ticks = cur.ticks - lspd_pkg::DelayWidth'(1);
          end
        end
      end
      lspd_pkg::OP_FLUSH: begin
        upd.ev_flush = cur.ev_now;
        if (cur.ev_now == lspd_pkg::EV_SHORT) begin
          upd.ev_now = lspd_pkg::EV_NONE;
        end
      end
      default: begin
        upd = cur;
      end
    endcase
  end

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    ch_idx_d    = ch_idx_q;
    ch_ok_d     = ch_ok_q;
    lvl_d       = lvl_q;
    sweep_d     = sweep_q;
    rd_busy_d   = rd_busy_q;
    rd_idx_d    = rd_idx_q;
    pend_d      = 1'b0;
    wr_idx_d    = wr_idx_q;
    res_val_d   = res_val_q;
    res_edge_d  = res_edge_q;
    out_valid_d = out_valid_q;
    out_val_d   = out_val_q;
    out_edge_d  = out_edge_q;
    vld_d       = vld_q;
    we          = 1'b0;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      lspd_pkg::ST_IDLE: begin
        if (in_ok) begin
          op_d       = lspd_pkg::op_e'(in_i.op);
          ch_idx_d   = IW'(in_i.channel);
          ch_ok_d    = in_valid_ch;
          lvl_d      = in_i.level;
          sweep_d    = in_sweep;
          res_val_d  = '0;
          res_edge_d = 1'b0;
          rd_idx_d   = in_sweep ? '0 : IW'(in_i.channel);
          rd_busy_d  = in_sweep || in_valid_ch;
          state_d    = (in_sweep || in_valid_ch) ? lspd_pkg::ST_RUN : lspd_pkg::ST_DONE;
        end
      end
      lspd_pkg::ST_RUN: begin
        pend_d   = rd_busy_q;
        wr_idx_d = rd_idx_q;
        if (rd_busy_q) begin
          if (sweep_q && (rd_idx_q != LastIdx)) begin
            rd_idx_d = rd_idx_q + IW'(1);
          end else begin
            rd_busy_d = 1'b0;
          end
        end
        if (pend_q) begin
          we              = 1'b1;
          vld_d[wr_idx_q] = 1'b1;
          if (ch_ok_q && (wr_idx_q == ch_idx_q)) begin
            res_val_d  = upd.ev_now;
            res_edge_d = (upd.ev_now != upd.ev_flush);
          end
          if (!rd_busy_q) begin
            state_d = lspd_pkg::ST_DONE;
          end
        end
      end
      lspd_pkg::ST_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_val_d   = res_val_q;
          out_edge_d  = res_edge_q;
          state_d     = lspd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = lspd_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lspd_pkg::ST_IDLE;
      rd_busy_q   <= 1'b0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
      vld_q       <= '0;
    end else begin
      state_q     <= state_d;
      rd_busy_q   <= rd_busy_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
      vld_q       <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    ch_idx_q   <= ch_idx_d;
    ch_ok_q    <= ch_ok_d;
    lvl_q      <= lvl_d;
    sweep_q    <= sweep_d;
    rd_idx_q   <= rd_idx_d;
    wr_idx_q   <= wr_idx_d;
    res_val_q  <= res_val_d;
    res_edge_q <= res_edge_d;
    out_val_q  <= out_val_d;
    out_edge_q <= out_edge_d;
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.event_value = out_val_q;
  assign out_o.event_edge  = out_edge_q;

endmodule

// ----- rtl/core/long_short_press_detector_unit.sv -----
// Top level of the long/short press detector: configuration port and state sequencer.
// Depends on lspd_pkg, lspd_intf, lspd_cfg, lspd_ctrl and lspd_ram.
//
//   Port     Kind          Carries
//   in_i     valid/ready   op, channel, level
//   out_o    valid/ready   event_value, event_edge
//   APB      psel/penable  press_delay_ticks at byte address 0
//
// Sample and query read and write back one state RAM entry; tick and flush
// sweep every entry of the state RAM, one entry read per cycle.
// Reset is asynchronous; per-entry valid flops make unwritten entries read as zero.
// A new item is taken once the previous result sits in the output register; a
// stalled output holds the following result until the register frees.
module long_short_press_detector_unit #(
  parameter int unsigned CHANNELS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  lspd_in_if.sink     in_i,
  lspd_out_if.source  out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [lspd_pkg::DelayWidth-1:0] delay;

  lspd_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .delay_o (delay)
  );

  lspd_ctrl #(
    .CHANNELS (CHANNELS)
  ) u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .delay_i (delay),
    .in_i    (in_i),
    .out_o   (out_o)
  );

endmodule
